>>> rtl/rbp_pkg.sv
// shared types and constants for the beam pose pipeline
`default_nettype none
package rbp_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W = 25;
   localparam int SQ_W = 48;
   localparam int SUM_W = 50;
   localparam int LEN_W = 25;
   localparam int ROT_FRAC = 15;
   localparam int UNIT_Q_W = 16;
   localparam int UNIT_NUM_W = LEN_W + UNIT_Q_W;
   localparam int UNIT_W = 17;
   localparam int W_ARG_W = 32;
   localparam int W_W = 16;
   localparam int RDEN_W = 17;
   localparam int ROT_Q_W = 15;
   localparam int ROT_NUM_W = RDEN_W + ROT_Q_W;
   localparam int POLE_W = 15;
   localparam int MINLEN_W = 16;
   localparam int PROD_W = POLE_W + LEN_W;

   localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 16'd655;
   localparam logic [POLE_W-1:0] POLE_LIMIT_RESET = 15'd32764;
   localparam logic [ROT_FRAC-1:0] ROT_ONE_MAX = 15'h7fff;
   localparam logic [COORD_W-1:0] LEN_SAT = 24'hffffff;

   typedef enum logic {
      CSR_MIN_LENGTH,
      CSR_POLE_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_UP,
      MODE_DOWN
   } mode_type;

   typedef struct packed {
      logic hand;
      logic visible;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic beam_hand;
      logic [COORD_W-1:0] quad_length;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_z;
      logic [14:0] rot_w;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] mid_z;
   } rsp_type;

   typedef struct packed {
      logic hand;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] mid_z;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
   } beam_tag_type;

   typedef struct packed {
      logic hand;
      logic [COORD_W-1:0] length;
      mode_type mode;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] mid_z;
   } pose_tag_type;

   typedef struct packed {
      pose_tag_type pose;
      logic signed [UNIT_W-1:0] ux;
      logic signed [UNIT_W-1:0] uz;
   } unit_tag_type;

   typedef struct packed {
      pose_tag_type pose;
      logic [W_W-1:0] w;
      logic neg_x;
      logic sat_x;
      logic sat_z;
   } rot_tag_type;

endpackage
`default_nettype wire

>>> rtl/rbp_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module rbp_sqrt
   import rbp_pkg::*;
#(
   parameter int IN_W = 50,
   parameter int TAG_W = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [IN_W-1:0]    in_radicand,
   input  wire logic [TAG_W-1:0]   in_tag,
   output logic                    out_valid,
   output logic [IN_W/2-1:0]       out_root,
   output logic [TAG_W-1:0]        out_tag
);

   localparam int ROOT_W = IN_W / 2;
   localparam int STAGES = ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic              valid_ff [1:STAGES];
   logic [ROOT_W-1:0] root_ff  [1:STAGES];
   logic [TAG_W-1:0]  tag_ff   [1:STAGES];
   logic [IN_W-1:0]   v_ff     [1:STAGES-1];
   logic [REM_W-1:0]  rem_ff   [1:STAGES-1];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic              valid_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [TAG_W-1:0]  tag_cur;
      logic [IN_W-1:0]   v_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W+1:0]  trial;
      logic              take;

      if (k == 0) begin : g_first
         assign valid_cur = in_valid;
         assign root_cur = '0;
         assign tag_cur = in_tag;
         assign v_cur = in_radicand;
         assign rem_cur = '0;
      end else begin : g_next
         assign valid_cur = valid_ff[k];
         assign root_cur = root_ff[k];
         assign tag_cur = tag_ff[k];
         assign v_cur = v_ff[k];
         assign rem_cur = rem_ff[k];
      end

      assign rem_sh = {rem_cur, v_cur[IN_W-1 -: 2]};
      assign trial = {2'b00, root_cur, 2'b01};
      assign take = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k+1] <= {root_cur[ROOT_W-2:0], take};
            tag_ff[k+1] <= tag_cur;
         end
      end

      if (k < STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               v_ff[k+1] <= v_cur << 2;
               rem_ff[k+1] <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            end
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_root = root_ff[STAGES];
   assign out_tag = tag_ff[STAGES];

endmodule
`default_nettype wire

>>> rtl/rbp_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
`default_nettype none
module rbp_div
   import rbp_pkg::*;
#(
   parameter int DEN_W = 25,
   parameter int Q_W = 16,
   parameter int TAG_W = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [DEN_W+Q_W-1:0]   in_num,
   input  wire logic [DEN_W-1:0]       in_den,
   input  wire logic [TAG_W-1:0]       in_tag,
   output logic                        out_valid,
   output logic [Q_W-1:0]              out_quo,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int NUM_W = DEN_W + Q_W;

   logic             valid_ff [1:Q_W];
   logic [Q_W-1:0]   q_ff     [1:Q_W];
   logic [TAG_W-1:0] tag_ff   [1:Q_W];
   logic [Q_W-1:0]   lo_ff    [1:Q_W-1];
   logic [DEN_W-1:0] rem_ff   [1:Q_W-1];
   logic [DEN_W-1:0] den_ff   [1:Q_W-1];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic             valid_cur;
      logic [Q_W-1:0]   q_cur;
      logic [TAG_W-1:0] tag_cur;
      logic [Q_W-1:0]   lo_cur;
      logic [DEN_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [DEN_W:0]   rem_sh;
      logic             take;

      if (k == 0) begin : g_first
         assign valid_cur = in_valid;
         assign q_cur = '0;
         assign tag_cur = in_tag;
         assign lo_cur = in_num[Q_W-1:0];
         assign rem_cur = in_num[NUM_W-1:Q_W];
         assign den_cur = in_den;
      end else begin : g_next
         assign valid_cur = valid_ff[k];
         assign q_cur = q_ff[k];
         assign tag_cur = tag_ff[k];
         assign lo_cur = lo_ff[k];
         assign rem_cur = rem_ff[k];
         assign den_cur = den_ff[k];
      end

      assign rem_sh = {rem_cur, lo_cur[Q_W-1]};
      assign take = (rem_sh >= {1'b0, den_cur});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k+1] <= {q_cur[Q_W-2:0], take};
            tag_ff[k+1] <= tag_cur;
         end
      end

      if (k < Q_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               lo_ff[k+1] <= lo_cur << 1;
               rem_ff[k+1] <= take ? DEN_W'(rem_sh - {1'b0, den_cur}) : DEN_W'(rem_sh);
               den_ff[k+1] <= den_cur;
            end
         end
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quo = q_ff[Q_W];
   assign out_tag = tag_ff[Q_W];

endmodule
`default_nettype wire

>>> rtl/ray_beam_pose_calc.sv
// beam pose pipeline: length, midpoint and rotation from +Y for each beam
// one beam per cycle from accepted request to response while the response is not stalled
// the length root (25 stages), unit divide (16), w root (16) and final divide
// (15) are bit-per-stage pipelines; a stalled response freezes every stage
// synchronous reset empties the pipeline and loads min_length 655, pole_limit 32764
`default_nettype none
module ray_beam_pose_calc
   import rbp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [15:0]   csr_data
);

   function automatic logic signed [COORD_W-1:0] mid_calc(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [DIFF_W-1:0] sum;
      sum = DIFF_W'(a) + DIFF_W'(b);
      return sum[DIFF_W-1:1];
   endfunction

   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] m;
      m = (d < 0) ? -d : d;
      return m[COORD_W-1:0];
   endfunction

   logic en;
   logic [MINLEN_W-1:0] min_length_ff;
   logic [POLE_W-1:0] pole_limit_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign en = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         pole_limit_ff <= POLE_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_LENGTH: min_length_ff <= csr_data;
            CSR_POLE_LIMIT: pole_limit_ff <= csr_data[POLE_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: differences and midpoints
   logic s1_valid_ff;
   beam_tag_type s1_tag_ff, s1_tag_in;

   always_comb begin
      s1_tag_in.hand = req_data.hand;
      s1_tag_in.mid_x = mid_calc(req_data.origin_x, req_data.end_x);
      s1_tag_in.mid_y = mid_calc(req_data.origin_y, req_data.end_y);
      s1_tag_in.mid_z = mid_calc(req_data.origin_z, req_data.end_z);
      s1_tag_in.dx = DIFF_W'(req_data.end_x) - DIFF_W'(req_data.origin_x);
      s1_tag_in.dy = DIFF_W'(req_data.end_y) - DIFF_W'(req_data.origin_y);
      s1_tag_in.dz = DIFF_W'(req_data.end_z) - DIFF_W'(req_data.origin_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid && req_data.visible;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff <= s1_tag_in;
      end
   end

   // stage 2: squares
   logic s2_valid_ff;
   beam_tag_type s2_tag_ff;
   logic [SQ_W-1:0] s2_sq_x_ff, s2_sq_y_ff, s2_sq_z_ff;
   logic [SQ_W-1:0] s2_sq_x_in, s2_sq_y_in, s2_sq_z_in;
   logic [COORD_W-1:0] s2_ax, s2_ay, s2_az;

   always_comb begin
      s2_ax = abs_diff(s1_tag_ff.dx);
      s2_ay = abs_diff(s1_tag_ff.dy);
      s2_az = abs_diff(s1_tag_ff.dz);
      s2_sq_x_in = s2_ax * s2_ax;
      s2_sq_y_in = s2_ay * s2_ay;
      s2_sq_z_in = s2_az * s2_az;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_tag_ff <= s1_tag_ff;
         s2_sq_x_ff <= s2_sq_x_in;
         s2_sq_y_ff <= s2_sq_y_in;
         s2_sq_z_ff <= s2_sq_z_in;
      end
   end

   // stage 3: sum of squares
   logic s3_valid_ff;
   beam_tag_type s3_tag_ff;
   logic [SUM_W-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_tag_ff <= s2_tag_ff;
         s3_sum_ff <= SUM_W'(s2_sq_x_ff) + SUM_W'(s2_sq_y_ff) + SUM_W'(s2_sq_z_ff);
      end
   end

   // beam length
   logic len_valid;
   logic [LEN_W-1:0] len_root;
   logic [$bits(beam_tag_type)-1:0] len_tag_bits;
   beam_tag_type len_tag;

   rbp_sqrt #(
      .IN_W  (SUM_W),
      .TAG_W ($bits(beam_tag_type))
   ) u_len_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s3_valid_ff),
      .in_radicand (s3_sum_ff),
      .in_tag      (s3_tag_ff),
      .out_valid   (len_valid),
      .out_root    (len_root),
      .out_tag     (len_tag_bits)
   );

   assign len_tag = beam_tag_type'(len_tag_bits);

   // stage a: length filter and pole product
   logic sa_valid_ff;
   beam_tag_type sa_tag_ff;
   logic [LEN_W-1:0] sa_len_ff;
   logic [PROD_W-1:0] sa_prod_ff, sa_prod_in;
   logic [PROD_W-2:0] sa_ay_sh_ff;

   assign sa_prod_in = pole_limit_ff * len_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (en) begin
         sa_valid_ff <= len_valid && (len_root >= LEN_W'(min_length_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_tag_ff <= len_tag;
         sa_len_ff <= len_root;
         sa_prod_ff <= sa_prod_in;
         sa_ay_sh_ff <= {abs_diff(len_tag.dy), {ROT_FRAC{1'b0}}};
      end
   end

   // stage b: pole decision and divider operands
   logic sb_valid_ff;
   pose_tag_type sb_pose_ff, sb_pose_in;
   logic [UNIT_NUM_W-1:0] sb_num_x_ff, sb_num_y_ff, sb_num_z_ff;
   logic [LEN_W-1:0] sb_len_ff;
   logic sb_neg_x_ff, sb_neg_y_ff, sb_neg_z_ff;
   logic sb_over;

   always_comb begin
      sb_over = ({1'b0, sa_ay_sh_ff} > sa_prod_ff);
      sb_pose_in.hand = sa_tag_ff.hand;
      sb_pose_in.length = sa_len_ff[LEN_W-1] ? LEN_SAT : sa_len_ff[COORD_W-1:0];
      sb_pose_in.mid_x = sa_tag_ff.mid_x;
      sb_pose_in.mid_y = sa_tag_ff.mid_y;
      sb_pose_in.mid_z = sa_tag_ff.mid_z;
      if (sa_len_ff == '0 || (sa_tag_ff.dy > 0 && sb_over)) begin
         sb_pose_in.mode = MODE_UP;
      end else if (sa_tag_ff.dy < 0 && sb_over) begin
         sb_pose_in.mode = MODE_DOWN;
      end else begin
         sb_pose_in.mode = MODE_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (en) begin
         sb_valid_ff <= sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_pose_ff <= sb_pose_in;
         sb_len_ff <= sa_len_ff;
         sb_num_x_ff <= {2'b00, abs_diff(sa_tag_ff.dx), {ROT_FRAC{1'b0}}};
         sb_num_y_ff <= {2'b00, abs_diff(sa_tag_ff.dy), {ROT_FRAC{1'b0}}};
         sb_num_z_ff <= {2'b00, abs_diff(sa_tag_ff.dz), {ROT_FRAC{1'b0}}};
         sb_neg_x_ff <= sa_tag_ff.dx < 0;
         sb_neg_y_ff <= sa_tag_ff.dy < 0;
         sb_neg_z_ff <= sa_tag_ff.dz < 0;
      end
   end

   // unit direction
   logic [UNIT_Q_W-1:0] ux_quo, uy_quo, uz_quo;
   logic ux_neg, uy_neg;
   logic uz_valid;
   logic [$bits(pose_tag_type):0] uz_tag_bits;

   rbp_div #(
      .DEN_W (LEN_W),
      .Q_W   (UNIT_Q_W),
      .TAG_W (1)
   ) u_ux_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sb_valid_ff),
      .in_num    (sb_num_x_ff),
      .in_den    (sb_len_ff),
      .in_tag    (sb_neg_x_ff),
      .out_valid (),
      .out_quo   (ux_quo),
      .out_tag   (ux_neg)
   );

   rbp_div #(
      .DEN_W (LEN_W),
      .Q_W   (UNIT_Q_W),
      .TAG_W (1)
   ) u_uy_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sb_valid_ff),
      .in_num    (sb_num_y_ff),
      .in_den    (sb_len_ff),
      .in_tag    (sb_neg_y_ff),
      .out_valid (),
      .out_quo   (uy_quo),
      .out_tag   (uy_neg)
   );

   rbp_div #(
      .DEN_W (LEN_W),
      .Q_W   (UNIT_Q_W),
      .TAG_W ($bits(pose_tag_type) + 1)
   ) u_uz_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sb_valid_ff),
      .in_num    (sb_num_z_ff),
      .in_den    (sb_len_ff),
      .in_tag    ({sb_neg_z_ff, sb_pose_ff}),
      .out_valid (uz_valid),
      .out_quo   (uz_quo),
      .out_tag   (uz_tag_bits)
   );

   // stage c: signed unit components and w radicand
   logic sc_valid_ff;
   unit_tag_type sc_tag_ff, sc_tag_in;
   logic [W_ARG_W-1:0] sc_arg_ff;
   logic signed [UNIT_W-1:0] sc_uy;
   logic [UNIT_W-1:0] sc_base;

   always_comb begin
      sc_tag_in.pose = pose_tag_type'(uz_tag_bits[$bits(pose_tag_type)-1:0]);
      sc_tag_in.ux = {1'b0, ux_quo};
      if (ux_neg) begin
         sc_tag_in.ux = -sc_tag_in.ux;
      end
      sc_tag_in.uz = {1'b0, uz_quo};
      if (uz_tag_bits[$bits(pose_tag_type)]) begin
         sc_tag_in.uz = -sc_tag_in.uz;
      end
      sc_uy = {1'b0, uy_quo};
      if (uy_neg) begin
         sc_uy = -sc_uy;
      end
      // 1 + uy in Q2.15, always in 0..2
      sc_base = UNIT_W'(1 << ROT_FRAC) + UNIT_W'(sc_uy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (en) begin
         sc_valid_ff <= uz_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_tag_ff <= sc_tag_in;
         sc_arg_ff <= {1'b0, sc_base, {(ROT_FRAC-1){1'b0}}};
      end
   end

   // w = sqrt((1 + uy) / 2)
   logic w_valid;
   logic [W_W-1:0] w_root;
   logic [$bits(unit_tag_type)-1:0] w_tag_bits;
   unit_tag_type w_tag;

   rbp_sqrt #(
      .IN_W  (W_ARG_W),
      .TAG_W ($bits(unit_tag_type))
   ) u_w_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (sc_valid_ff),
      .in_radicand (sc_arg_ff),
      .in_tag      (sc_tag_ff),
      .out_valid   (w_valid),
      .out_root    (w_root),
      .out_tag     (w_tag_bits)
   );

   assign w_tag = unit_tag_type'(w_tag_bits);

   // stage d: overflow checks and 2w divider operands
   logic sd_valid_ff;
   rot_tag_type sd_tag_ff, sd_tag_in;
   logic [ROT_NUM_W-1:0] sd_num_x_ff, sd_num_z_ff;
   logic [RDEN_W-1:0] sd_den_ff, sd_den;
   logic sd_neg_z_ff;
   logic [UNIT_W-1:0] sd_mag_x, sd_mag_z;

   always_comb begin
      sd_den = {w_root, 1'b0};
      sd_mag_x = (w_tag.ux < 0) ? UNIT_W'(-w_tag.ux) : UNIT_W'(w_tag.ux);
      sd_mag_z = (w_tag.uz < 0) ? UNIT_W'(-w_tag.uz) : UNIT_W'(w_tag.uz);
      sd_tag_in.pose = w_tag.pose;
      sd_tag_in.w = w_root;
      sd_tag_in.neg_x = w_tag.uz < 0;
      sd_tag_in.sat_x = sd_mag_z >= sd_den;
      sd_tag_in.sat_z = sd_mag_x >= sd_den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_valid_ff <= 1'b0;
      end else if (en) begin
         sd_valid_ff <= w_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_tag_ff <= sd_tag_in;
         sd_den_ff <= sd_den;
         sd_num_x_ff <= {sd_mag_z, {ROT_FRAC{1'b0}}};
         sd_num_z_ff <= {sd_mag_x, {ROT_FRAC{1'b0}}};
         // rot_z takes -ux
         sd_neg_z_ff <= w_tag.ux > 0;
      end
   end

   // rotation x and z over 2w
   logic rx_valid;
   logic [ROT_Q_W-1:0] rx_quo, rz_quo;
   logic [$bits(rot_tag_type)-1:0] rx_tag_bits;
   logic rz_neg;
   rot_tag_type fin_tag;

   rbp_div #(
      .DEN_W (RDEN_W),
      .Q_W   (ROT_Q_W),
      .TAG_W ($bits(rot_tag_type))
   ) u_rx_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sd_valid_ff),
      .in_num    (sd_num_x_ff),
      .in_den    (sd_den_ff),
      .in_tag    (sd_tag_ff),
      .out_valid (rx_valid),
      .out_quo   (rx_quo),
      .out_tag   (rx_tag_bits)
   );

   rbp_div #(
      .DEN_W (RDEN_W),
      .Q_W   (ROT_Q_W),
      .TAG_W (1)
   ) u_rz_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sd_valid_ff),
      .in_num    (sd_num_z_ff),
      .in_den    (sd_den_ff),
      .in_tag    (sd_neg_z_ff),
      .out_valid (),
      .out_quo   (rz_quo),
      .out_tag   (rz_neg)
   );

   assign fin_tag = rot_tag_type'(rx_tag_bits);

   // final stage: pole snapping and saturation into the response register
   logic [ROT_FRAC-1:0] fin_mag_x, fin_mag_z;
   logic signed [15:0] fin_rx, fin_rz;

   always_comb begin
      fin_mag_x = fin_tag.sat_x ? ROT_ONE_MAX : rx_quo;
      fin_mag_z = fin_tag.sat_z ? ROT_ONE_MAX : rz_quo;
      fin_rx = fin_tag.neg_x ? -$signed({1'b0, fin_mag_x}) : $signed({1'b0, fin_mag_x});
      fin_rz = rz_neg ? -$signed({1'b0, fin_mag_z}) : $signed({1'b0, fin_mag_z});
      rsp_in.beam_hand = fin_tag.pose.hand;
      rsp_in.quad_length = fin_tag.pose.length;
      rsp_in.mid_x = fin_tag.pose.mid_x;
      rsp_in.mid_y = fin_tag.pose.mid_y;
      rsp_in.mid_z = fin_tag.pose.mid_z;
      if (fin_tag.pose.mode == MODE_UP) begin
         rsp_in.rot_x = '0;
         rsp_in.rot_z = '0;
         rsp_in.rot_w = ROT_ONE_MAX;
      end else if (fin_tag.pose.mode == MODE_DOWN || fin_tag.w == '0) begin
         rsp_in.rot_x = '0;
         rsp_in.rot_z = {1'b0, ROT_ONE_MAX};
         rsp_in.rot_w = '0;
      end else begin
         rsp_in.rot_x = fin_rx;
         rsp_in.rot_z = fin_rz;
         rsp_in.rot_w = fin_tag.w[W_W-1] ? ROT_ONE_MAX : fin_tag.w[ROT_FRAC-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/rbp_checker.sv
// port-level checks for the beam pose pipeline, bound to the top level
`default_nettype none
module rbp_checker
   import rbp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a stalled response transaction stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // input backpressure only comes from a blocked response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response backpressure");

   // the pipeline is empty right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // zero w only comes from the half-turn snap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rot_w == '0 |->
         rsp_data.rot_x == '0 && rsp_data.rot_z == 16'sd32767)
      else $error("zero w without half-turn");

endmodule

bind ray_beam_pose_calc rbp_checker u_rbp_checker (.*);
`default_nettype wire

>>> sim/tb.sv
// testbench for the beam pose pipeline: directed, register, random, quiesce and back-to-back beams
module tb;
   import rbp_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_MIN_LENGTH;
   logic [15:0]   csr_data = '0;

   logic [MINLEN_W-1:0] min_len_reg = MIN_LENGTH_RESET;
   logic [POLE_W-1:0]   pole_reg = POLE_LIMIT_RESET;
   rsp_type             pose_q[$];
   bit                  quiet = 1'b0;
   int                  errors = 0;
   int                  dead_cycles = 0;

   localparam int DEAD_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   ray_beam_pose_calc dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // truncating divide of a * 2^sh by den
   function automatic longint frac_div(longint a, int sh, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (a < 0) ? longint'(-a) : a;
      q = (mag << sh) / den;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // returns 1 when the beam produces a pose
   function automatic bit beam_pose(req_type r, output rsp_type p);
      longint dx, dy, dz, ux, uy, uz, rx, rz, rw;
      longint unsigned ax, ay, az, len, w;
      longint one_max;
      one_max = (64'sd1 << ROT_FRAC) - 1;
      p = '0;
      rx = 0;
      rz = 0;
      rw = 0;
      dx = longint'(r.end_x) - longint'(r.origin_x);
      dy = longint'(r.end_y) - longint'(r.origin_y);
      dz = longint'(r.end_z) - longint'(r.origin_z);
      if (!r.visible) return 1'b0;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      len = int_root(ax * ax + ay * ay + az * az);
      if (len < min_len_reg) return 1'b0;
      if (len == 0 || (dy > 0 && (ay << 15) > pole_reg * len)) begin
         rw = one_max;
      end else if (dy < 0 && (ay << 15) > pole_reg * len) begin
         rz = one_max;
      end else begin
         ux = frac_div(dx, ROT_FRAC, len);
         uy = frac_div(dy, ROT_FRAC, len);
         uz = frac_div(dz, ROT_FRAC, len);
         w = int_root(longint'((64'sd1 << ROT_FRAC) + uy) << (ROT_FRAC - 1));
         if (w == 0) begin
            rz = one_max;
         end else begin
            rx = clip_sym(frac_div(uz, ROT_FRAC, 2 * w), one_max);
            rz = clip_sym(frac_div(-ux, ROT_FRAC, 2 * w), one_max);
            rw = (longint'(w) > one_max) ? one_max : longint'(w);
         end
      end
      p.beam_hand = r.hand;
      p.quad_length = (len > LEN_SAT) ? LEN_SAT : len[COORD_W-1:0];
      p.rot_x = rx[15:0];
      p.rot_z = rz[15:0];
      p.rot_w = rw[14:0];
      p.mid_x = (longint'(r.origin_x) + longint'(r.end_x)) >>> 1;
      p.mid_y = (longint'(r.origin_y) + longint'(r.end_y)) >>> 1;
      p.mid_z = (longint'(r.origin_z) + longint'(r.end_z)) >>> 1;
      return 1'b1;
   endfunction

   task automatic send_beam(req_type r);
      rsp_type p;
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (beam_pose(r, p)) pose_q.push_back(p);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // let every pending pose and any filtered beam leave the pipeline
   task automatic settle();
      drop_valid();
      while (pose_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MIN_LENGTH) min_len_reg = v;
      else pole_reg = v[POLE_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type beam_of(bit h, bit vis, int ox, int oy, int oz,
                                       int ex, int ey, int ez);
      req_type r;
      r.hand = h;
      r.visible = vis;
      r.origin_x = ox;
      r.origin_y = oy;
      r.origin_z = oz;
      r.end_x = ex;
      r.end_y = ey;
      r.end_z = ez;
      return r;
   endfunction

   function automatic int rand_coord();
      return int'($urandom) >>> 8;
   endfunction

   function automatic int rand_delta();
      case ($urandom_range(0, 3))
         0: return int'($urandom_range(0, 8191)) - 4096;
         1: return int'($urandom_range(0, 262143)) - 131072;
         2: return int'($urandom_range(0, 4194303)) - 2097152;
         default: return int'($urandom_range(0, 31)) - 16;
      endcase
   endfunction

   function automatic req_type rand_beam();
      int ox, oy, oz, dx, dy, dz;
      ox = rand_coord();
      oy = rand_coord();
      oz = rand_coord();
      dx = rand_delta();
      dy = rand_delta();
      dz = rand_delta();
      // some beams point almost straight up or down
      if ($urandom_range(0, 7) == 0) begin
         dx = int'($urandom_range(0, 6)) - 3;
         dz = int'($urandom_range(0, 6)) - 3;
      end
      if ($urandom_range(0, 9) == 0)
         return beam_of($urandom, $urandom, ox, oy, oz, rand_coord(), rand_coord(),
                        rand_coord());
      return beam_of($urandom, $urandom_range(0, 9) != 0, ox, oy, oz,
                     ox + dx, oy + dy, oz + dz);
   endfunction

   task automatic test_directed();
      send_beam(beam_of(0, 1, 0, 0, 0, 65536, 0, 0));
      send_beam(beam_of(1, 1, 0, 0, 0, 0, 0, -65536));
      send_beam(beam_of(0, 1, 100, 200, 300, 100, 70000, 300));
      send_beam(beam_of(1, 1, 100, 200, 300, 100, -70000, 300));
      send_beam(beam_of(0, 0, 0, 0, 0, 65536, 65536, 65536));
      send_beam(beam_of(1, 1, 0, 0, 0, 654, 0, 0));
      send_beam(beam_of(0, 1, 0, 0, 0, 655, 0, 0));
      send_beam(beam_of(1, 1, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
      send_beam(beam_of(0, 1, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
      send_beam(beam_of(1, 1, -8388608, 8388607, 0, 8388607, -8388608, 0));
      send_beam(beam_of(0, 1, -3, -5, -7, 40000, 1000, -40000));
      send_beam(beam_of(1, 1, 0, 0, 0, 10, 65536, -10));
      send_beam(beam_of(0, 1, 0, 0, 0, -10, -65536, 10));
      settle();
      write_csr(CSR_MIN_LENGTH, 16'd0);
      send_beam(beam_of(1, 1, 5, 5, 5, 5, 5, 5));
      send_beam(beam_of(0, 1, -1, -1, -1, -2, -2, -2));
      send_beam(beam_of(1, 1, 0, 0, 0, 1, 0, 0));
   endtask

   task automatic test_registers();
      settle();
      write_csr(CSR_MIN_LENGTH, 16'hffff);
      write_csr(CSR_POLE_LIMIT, 16'd0);
      send_beam(beam_of(0, 1, 0, 0, 0, 65535, 0, 0));
      send_beam(beam_of(1, 1, 0, 0, 0, 65536, 1, 0));
      send_beam(beam_of(0, 1, 0, 0, 0, 65536, -1, 0));
      send_beam(beam_of(1, 1, 0, 0, 0, 300000, 0, 5));
      settle();
      write_csr(CSR_POLE_LIMIT, 16'h7fff);
      send_beam(beam_of(0, 1, 0, 0, 0, 0, 200000, 0));
      send_beam(beam_of(1, 1, 0, 0, 0, 0, -200000, 0));
      send_beam(beam_of(0, 1, 0, 0, 0, 1, -200000, 0));
   endtask

   task automatic run_random(int count);
      repeat (count) send_beam(rand_beam());
   endtask

   task automatic test_random();
      settle();
      write_csr(CSR_MIN_LENGTH, MIN_LENGTH_RESET);
      write_csr(CSR_POLE_LIMIT, POLE_LIMIT_RESET);
      run_random(300);
      settle();
      write_csr(CSR_MIN_LENGTH, 16'd0);
      write_csr(CSR_POLE_LIMIT, 16'd20000);
      run_random(300);
      settle();
      write_csr(CSR_MIN_LENGTH, 16'd5000);
      write_csr(CSR_POLE_LIMIT, 16'h7fff);
      run_random(300);
   endtask

   // sender holds off until the pipeline has returned every pose
   task automatic test_quiesce();
      run_random(50);
      settle();
      run_random(50);
   endtask

   task automatic test_back_to_back();
      settle();
      write_csr(CSR_MIN_LENGTH, 16'd100);
      write_csr(CSR_POLE_LIMIT, 16'd32000);
      quiet = 1'b1;
      run_random(230);
      drop_valid();
   endtask

   initial begin : receiver_stall
      int n;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : pose_check
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_q.size() == 0) begin
            $error("pose with no beam pending: %p", rsp_data);
            errors++;
         end else begin
            e = pose_q.pop_front();
            if (rsp_data.beam_hand !== e.beam_hand) begin
               $error("beam_hand expected %0d got %0d", e.beam_hand, rsp_data.beam_hand);
               errors++;
            end
            if (rsp_data.quad_length !== e.quad_length) begin
               $error("quad_length expected %0d got %0d", e.quad_length,
                      rsp_data.quad_length);
               errors++;
            end
            if (rsp_data.rot_x !== e.rot_x) begin
               $error("rot_x expected %0d got %0d", e.rot_x, rsp_data.rot_x);
               errors++;
            end
            if (rsp_data.rot_z !== e.rot_z) begin
               $error("rot_z expected %0d got %0d", e.rot_z, rsp_data.rot_z);
               errors++;
            end
            if (rsp_data.rot_w !== e.rot_w) begin
               $error("rot_w expected %0d got %0d", e.rot_w, rsp_data.rot_w);
               errors++;
            end
            if (rsp_data.mid_x !== e.mid_x) begin
               $error("mid_x expected %0d got %0d", e.mid_x, rsp_data.mid_x);
               errors++;
            end
            if (rsp_data.mid_y !== e.mid_y) begin
               $error("mid_y expected %0d got %0d", e.mid_y, rsp_data.mid_y);
               errors++;
            end
            if (rsp_data.mid_z !== e.mid_z) begin
               $error("mid_z expected %0d got %0d", e.mid_z, rsp_data.mid_z);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         dead_cycles <= 0;
      end else begin
         dead_cycles <= dead_cycles + 1;
         if (dead_cycles >= DEAD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_registers();
      test_random();
      test_quiesce();
      test_back_to_back();
      while (pose_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pose_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
